>>> sv/cdq_pkg.sv
// Shared constants, request codes and cell control types for the circular deque.
package cdq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int S_TDATA_W = ((FUNC_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STAT_W + DATA_W + OCC_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DUMP       = 3'd4;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHR,
        CELL_SHL,
        CELL_PUSHB,
        CELL_POPB,
        CELL_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   push_data;
        logic [DATA_W-1:0]   head_data;
    } cell_ctrl_t;

endpackage

>>> sv/cdq_cell.sv
// One storage cell of the deque chain, holding an entry and its valid flag.
module cdq_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cdq_pkg::cell_ctrl_t        ctrl,
    input  logic [cdq_pkg::DATA_W-1:0] left_data,
    input  logic                       left_valid,
    input  logic [cdq_pkg::DATA_W-1:0] right_data,
    input  logic                       right_valid,
    output logic [cdq_pkg::DATA_W-1:0] data_out,
    output logic                       valid_out
);
    import cdq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              valid_reg;
    logic              valid_next;
    logic              is_last;

    assign is_last = valid_reg && !right_valid;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
            end
            CELL_SHR: begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            CELL_SHL: begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            CELL_PUSHB: begin
                if (!valid_reg && left_valid) begin
                    data_next  = ctrl.push_data;
                    valid_next = 1'b1;
                end
            end
            CELL_POPB: begin
                if (is_last) begin
                    valid_next = 1'b0;
                end
            end
            CELL_ROT: begin
                if (is_last) begin
                    data_next = ctrl.head_data;
                end else if (valid_reg) begin
                    data_next = right_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;

endmodule

>>> sv/circular_deque_core.sv
// Top level of the circular deque: a chain of storage cells with request control.
// Entries sit packed in a row of cells, front in the first cell; pushes and pops
// shift the row or touch its tail, and each of them gives one registered result;
// a new request is taken in every cycle while results are being taken.
// A dump of n entries gives n results, one a cycle while they are taken, by rotating
// the occupied cells past the head; its first result comes in the cycle after a push's
// would, and it takes no new request until its final result has been taken.
// A dump on an empty queue, and every other request, gives a single result.
module circular_deque_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata fields from bit 0: func[2:0], value[31:0], zero padding.
    input  logic [cdq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata fields from bit 0: status[1:0], item[31:0], occupancy[4:0], zero padding.
    output logic [cdq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   dump_left_reg, dump_left_next;
    logic               m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [DATA_W-1:0]  item_reg, item_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic               last_reg, last_next;

    cell_ctrl_t         ctrl;
    logic [DATA_W-1:0]  cell_data [DEPTH];
    logic               cell_valid [DEPTH];
    logic [DATA_W-1:0]  tail_data;

    logic [FUNC_W-1:0]  func;
    logic [DATA_W-1:0]  value;
    logic               out_free;
    logic               s_accept;
    logic               empty;
    logic               full;

    assign func     = s_tdata[FUNC_W-1:0];
    assign value    = s_tdata[FUNC_W +: DATA_W];
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] l_data;
        logic              l_valid;
        logic [DATA_W-1:0] r_data;
        logic              r_valid;

        if (i == 0) begin : g_head
            assign l_data  = value;
            assign l_valid = 1'b1;
        end else begin : g_mid
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end else begin : g_inner
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        cdq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data_out    (cell_data[i]),
            .valid_out   (cell_valid[i])
        );
    end

    always_comb begin
        tail_data = '0;
        for (int i = 0; i < DEPTH - 1; i++) begin
            if (cell_valid[i] && !cell_valid[i+1]) begin
                tail_data = tail_data | cell_data[i];
            end
        end
        if (cell_valid[DEPTH-1]) begin
            tail_data = tail_data | cell_data[DEPTH-1];
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_left_next = dump_left_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        status_next    = status_reg;
        item_next      = item_reg;
        occ_next       = occ_reg;
        last_next      = last_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.push_data = value;
        ctrl.head_data = cell_data[0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    m_valid_next = 1'b1;
                    status_next  = STATUS_OK;
                    item_next    = '0;
                    occ_next     = OCC_W'(count_reg);
                    last_next    = 1'b1;
                    unique case (func)
                        FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                            if (full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                ctrl.op    = (func == FUNC_PUSH_FRONT) ? CELL_SHR : CELL_PUSHB;
                                count_next = count_reg + CNT_W'(1);
                                occ_next   = OCC_W'(count_reg + CNT_W'(1));
                            end
                        end
                        FUNC_POP_FRONT, FUNC_POP_BACK: begin
                            if (empty) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                ctrl.op    = (func == FUNC_POP_FRONT) ? CELL_SHL : CELL_POPB;
                                item_next  = (func == FUNC_POP_FRONT) ? cell_data[0] : tail_data;
                                count_next = count_reg - CNT_W'(1);
                                occ_next   = OCC_W'(count_reg - CNT_W'(1));
                            end
                        end
                        FUNC_DUMP: begin
                            if (empty) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                m_valid_next   = 1'b0;
                                dump_left_next = count_reg;
                                state_next     = ST_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    status_next    = STATUS_OK;
                    item_next      = cell_data[0];
                    occ_next       = OCC_W'(count_reg);
                    last_next      = (dump_left_reg == CNT_W'(1));
                    ctrl.op        = CELL_ROT;
                    dump_left_next = dump_left_reg - CNT_W'(1);
                    if (dump_left_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_left_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_left_reg <= dump_left_next;
            m_valid_reg   <= m_valid_next;
        end
        status_reg <= status_next;
        item_reg   <= item_next;
        occ_reg    <= occ_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(M_TDATA_W - STAT_W - DATA_W - OCC_W){1'b0}},
                       occ_reg, item_reg, status_reg};

endmodule

>>> sv/cdq_checker.sv
// Port-level checks on the circular deque core, bound to its top level.
module cdq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cdq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import cdq_pkg::*;

    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occ;

    assign status = m_tdata[STAT_W-1:0];
    assign occ    = m_tdata[STAT_W + DATA_W +: OCC_W];

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_no_request_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while a result waits");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (status == STATUS_OK) || (status == STATUS_EMPTY)
                     || (status == STATUS_FULL))
        else $error("undefined status code");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> occ <= OCC_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_dump_mid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> status == STATUS_OK && !s_tready)
        else $error("non-final result without ok status or with request open");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
